FILE: rtl/framed_lz_decompressor_unit_macros.svh
// Assertion helpers for the checker file.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef FRAMED_LZ_DECOMPRESSOR_UNIT_MACROS_SVH
`define FRAMED_LZ_DECOMPRESSOR_UNIT_MACROS_SVH

// The property must hold in the same cycle as the condition.
`define FLZ_ASSERT_HOLDS(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// The property must hold in the cycle after the condition.
`define FLZ_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: rtl/flz_pkg.sv
package flz_pkg;

    localparam int MAX_FRAME_BYTES = 508;
    localparam int HISTORY_DEPTH   = 512;
    localparam int HIST_AW         = $clog2(HISTORY_DEPTH);
    localparam int FP_W            = $clog2(MAX_FRAME_BYTES + 1);
    localparam int TOTAL_W         = 22;
    localparam int LEN_W           = 16;
    localparam int OFF_W           = 12;
    localparam int RUN_W           = 8;
    localparam int MLEN_W          = 4;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);

    localparam logic [TOTAL_W-1:0] CAPACITY_RESET = TOTAL_W'(2097152);
    localparam logic [LEN_W-1:0]   MAX_RAW        = LEN_W'(MAX_FRAME_BYTES);
    localparam logic [MLEN_W-1:0]  MATCH_BASE     = MLEN_W'(3);
    localparam logic [1:0]         HDR_LAST       = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_STORED,
        PH_TOKEN,
        PH_LITERAL,
        PH_MATCH
    } phase_t;

    typedef enum logic [1:0] {
        CMD_LIT,
        CMD_STORED,
        CMD_MATCH,
        CMD_STATUS
    } cmd_op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_COPY
    } bk_state_t;

    // One request from the parser to the output engine.
    typedef struct packed {
        cmd_op_t              op;
        logic [7:0]           data;
        logic                 ok;
        logic [HIST_AW-1:0]   wr_addr;
        logic [HIST_AW-1:0]   rd_addr;
        logic [MLEN_W-1:0]    count;
        logic [TOTAL_W-1:0]   total;
    } cmd_t;

endpackage

FILE: rtl/framed_lz_decompressor_unit.sv
// Framed LZ decompressor. Compressed bytes enter on the in channel (opcode 0
// with in_byte), and an end-of-stream request is opcode 1. Results leave on
// the out channel: kind 0 carries one decompressed byte, kind 1 or 2 is the
// end-of-stream status, and total_length is the running output count. last
// marks the final result caused by one input request.
// The cfg channel writes the output capacity at any time the block is idle;
// it is always ready.
// Input requests are taken one per cycle while the four-entry command queue
// between the parser and the output engine has room. A literal or stored
// byte, or a status, goes from the queue into the output register once the
// engine is idle and the output register is free. A match copies its 3 to
// 10 bytes from the history memory, each by a read state and then a copy
// state that writes the byte back and loads it into the output register.
// Reset clears the parser, the queue and the output register and sets the
// capacity to 2097152; the history memory needs no clearing. When the
// receiver stalls, the output register holds its result, the engine waits,
// the queue fills and in_ready drops.
module framed_lz_decompressor_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [flz_pkg::TOTAL_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          opcode,
    input  logic [7:0]                    in_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    kind,
    output logic [7:0]                    out_byte,
    output logic [flz_pkg::TOTAL_W-1:0]   total_length,
    output logic                          last
);

    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    flz_pkg::cmd_t push_cmd;
    flz_pkg::cmd_t pop_cmd;

    flz_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .in_byte   (in_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    flz_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    flz_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_cmd        (pop_cmd),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .out_byte     (out_byte),
        .total_length (total_length),
        .last         (last)
    );

endmodule

FILE: rtl/flz_queue.sv
module flz_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  flz_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output flz_pkg::cmd_t pop_cmd,
    output logic          empty
);

    flz_pkg::cmd_t                  entry_reg [flz_pkg::QUEUE_DEPTH];
    logic [flz_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [flz_pkg::QUEUE_AW-1:0]   wr_ptr_next;
    logic [flz_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [flz_pkg::QUEUE_AW-1:0]   rd_ptr_next;
    logic [flz_pkg::QUEUE_AW:0]     count_reg;
    logic [flz_pkg::QUEUE_AW:0]     count_next;
    logic                           do_push;
    logic                           do_pop;

    assign full    = (count_reg == (flz_pkg::QUEUE_AW + 1)'(flz_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/flz_front.sv
module flz_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [flz_pkg::TOTAL_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          opcode,
    input  logic [7:0]                    in_byte,
    input  logic                          q_full,
    output logic                          q_push,
    output flz_pkg::cmd_t                 q_cmd
);

    flz_pkg::phase_t                  phase_reg;
    flz_pkg::phase_t                  phase_next;
    logic [1:0]                       hdr_cnt_reg;
    logic [1:0]                       hdr_cnt_next;
    logic [flz_pkg::LEN_W-1:0]        raw_len_reg;
    logic [flz_pkg::LEN_W-1:0]        raw_len_next;
    logic [flz_pkg::LEN_W-1:0]        comp_rem_reg;
    logic [flz_pkg::LEN_W-1:0]        comp_rem_next;
    logic [flz_pkg::FP_W-1:0]         fp_reg;
    logic [flz_pkg::FP_W-1:0]         fp_next;
    logic [flz_pkg::RUN_W-1:0]        lit_rem_reg;
    logic [flz_pkg::RUN_W-1:0]        lit_rem_next;
    logic [7:0]                       token_reg;
    logic [7:0]                       token_next;
    logic [flz_pkg::TOTAL_W-1:0]      total_reg;
    logic [flz_pkg::TOTAL_W-1:0]      total_next;
    logic                             failed_reg;
    logic                             failed_next;
    logic [flz_pkg::TOTAL_W-1:0]      cap_reg;

    logic                             accept;
    logic [flz_pkg::TOTAL_W-1:0]      room;
    logic [flz_pkg::TOTAL_W-1:0]      total_inc;
    logic [flz_pkg::LEN_W-1:0]        fp_ext;
    logic [flz_pkg::LEN_W-1:0]        fp_inc;
    logic [flz_pkg::LEN_W-1:0]        comp_dec;
    logic [flz_pkg::LEN_W-1:0]        comp_full;
    logic [flz_pkg::RUN_W-1:0]        lit_n;
    logic [flz_pkg::MLEN_W-1:0]       m_len;
    logic [flz_pkg::OFF_W-1:0]        m_off;
    logic [flz_pkg::LEN_W-1:0]        fp_plus_lit;
    logic [flz_pkg::LEN_W-1:0]        fp_plus_m;
    logic                             status_ok;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        room        = (total_reg > cap_reg) ? '0 : cap_reg - total_reg;
        total_inc   = total_reg + 1'b1;
        fp_ext      = flz_pkg::LEN_W'(fp_reg);
        fp_inc      = fp_ext + 1'b1;
        comp_dec    = comp_rem_reg - 1'b1;
        comp_full   = {in_byte, comp_rem_reg[7:0]};
        lit_n       = {1'b0, in_byte[6:0]} + 1'b1;
        m_len       = {1'b0, token_reg[6:4]} + flz_pkg::MATCH_BASE;
        m_off       = {token_reg[3:0], in_byte};
        fp_plus_lit = fp_ext + flz_pkg::LEN_W'(lit_n);
        fp_plus_m   = fp_ext + flz_pkg::LEN_W'(m_len);
        status_ok   = !failed_reg && (phase_reg == flz_pkg::PH_HEADER) && (hdr_cnt_reg == '0);

        phase_next    = phase_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        raw_len_next  = raw_len_reg;
        comp_rem_next = comp_rem_reg;
        fp_next       = fp_reg;
        lit_rem_next  = lit_rem_reg;
        token_next    = token_reg;
        total_next    = total_reg;
        failed_next   = failed_reg;

        q_push          = 1'b0;
        q_cmd           = '0;
        q_cmd.op        = flz_pkg::CMD_LIT;
        q_cmd.data      = in_byte;
        q_cmd.ok        = status_ok;
        q_cmd.wr_addr   = flz_pkg::HIST_AW'(fp_reg);
        q_cmd.rd_addr   = flz_pkg::HIST_AW'(flz_pkg::OFF_W'(fp_reg) - m_off);
        q_cmd.count     = m_len;
        q_cmd.total     = total_inc;

        if (accept)
        begin
            if (opcode)
            begin
                q_push        = 1'b1;
                q_cmd.op      = flz_pkg::CMD_STATUS;
                q_cmd.data    = '0;
                q_cmd.total   = total_reg;
                phase_next    = flz_pkg::PH_HEADER;
                hdr_cnt_next  = '0;
                raw_len_next  = '0;
                comp_rem_next = '0;
                fp_next       = '0;
                lit_rem_next  = '0;
                token_next    = '0;
                total_next    = '0;
                failed_next   = 1'b0;
            end
            else if (!failed_reg)
            begin
                unique case (phase_reg)
                    flz_pkg::PH_HEADER:
                    begin
                        case (hdr_cnt_reg)
                            2'd0:    raw_len_next  = {8'h00, in_byte};
                            2'd1:    raw_len_next  = {in_byte, raw_len_reg[7:0]};
                            2'd2:    comp_rem_next = {8'h00, in_byte};
                            default: comp_rem_next = comp_full;
                        endcase
                        hdr_cnt_next = hdr_cnt_reg + 1'b1;
                        if (hdr_cnt_reg == flz_pkg::HDR_LAST)
                        begin
                            fp_next = '0;
                            if ((raw_len_reg == '0) || (raw_len_reg > flz_pkg::MAX_RAW) ||
                                (flz_pkg::TOTAL_W'(raw_len_reg) > room))
                            begin
                                failed_next = 1'b1;
                            end
                            else
                            begin
                                phase_next = (comp_full == '0) ? flz_pkg::PH_STORED
                                                               : flz_pkg::PH_TOKEN;
                            end
                        end
                    end
                    flz_pkg::PH_STORED:
                    begin
                        q_push     = 1'b1;
                        q_cmd.op   = flz_pkg::CMD_STORED;
                        fp_next    = flz_pkg::FP_W'(fp_inc);
                        total_next = total_inc;
                        if (fp_inc >= raw_len_reg)
                        begin
                            phase_next   = flz_pkg::PH_HEADER;
                            hdr_cnt_next = '0;
                        end
                    end
                    flz_pkg::PH_TOKEN:
                    begin
                        comp_rem_next = comp_dec;
                        if (!in_byte[7])
                        begin
                            if ((flz_pkg::LEN_W'(lit_n) > comp_dec) ||
                                (flz_pkg::TOTAL_W'(lit_n) > room) ||
                                (fp_plus_lit > raw_len_reg))
                            begin
                                failed_next = 1'b1;
                            end
                            else
                            begin
                                lit_rem_next = lit_n;
                                phase_next   = flz_pkg::PH_LITERAL;
                            end
                        end
                        else if (comp_dec == '0)
                        begin
                            // A match token needs one more byte inside the frame.
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            token_next = in_byte;
                            phase_next = flz_pkg::PH_MATCH;
                        end
                    end
                    flz_pkg::PH_LITERAL:
                    begin
                        comp_rem_next = comp_dec;
                        q_push        = 1'b1;
                        q_cmd.op      = flz_pkg::CMD_LIT;
                        fp_next       = flz_pkg::FP_W'(fp_inc);
                        total_next    = total_inc;
                        lit_rem_next  = lit_rem_reg - 1'b1;
                        if (lit_rem_reg == flz_pkg::RUN_W'(1))
                        begin
                            phase_next = flz_pkg::PH_TOKEN;
                            if (comp_dec == '0)
                            begin
                                if (fp_inc != raw_len_reg)
                                begin
                                    failed_next = 1'b1;
                                end
                                phase_next   = flz_pkg::PH_HEADER;
                                hdr_cnt_next = '0;
                            end
                        end
                    end
                    flz_pkg::PH_MATCH:
                    begin
                        comp_rem_next = comp_dec;
                        if ((m_off == '0) || (m_off > flz_pkg::OFF_W'(fp_reg)) ||
                            (flz_pkg::TOTAL_W'(m_len) > room) ||
                            (fp_plus_m > raw_len_reg))
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            q_push     = 1'b1;
                            q_cmd.op   = flz_pkg::CMD_MATCH;
                            fp_next    = flz_pkg::FP_W'(fp_plus_m);
                            total_next = total_reg + flz_pkg::TOTAL_W'(m_len);
                            phase_next = flz_pkg::PH_TOKEN;
                            if (comp_dec == '0)
                            begin
                                if (fp_plus_m != raw_len_reg)
                                begin
                                    failed_next = 1'b1;
                                end
                                phase_next   = flz_pkg::PH_HEADER;
                                hdr_cnt_next = '0;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = flz_pkg::PH_HEADER;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= flz_pkg::PH_HEADER;
            hdr_cnt_reg  <= '0;
            raw_len_reg  <= '0;
            comp_rem_reg <= '0;
            fp_reg       <= '0;
            lit_rem_reg  <= '0;
            token_reg    <= '0;
            total_reg    <= '0;
            failed_reg   <= 1'b0;
            cap_reg      <= flz_pkg::CAPACITY_RESET;
        end
        else
        begin
            phase_reg    <= phase_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            raw_len_reg  <= raw_len_next;
            comp_rem_reg <= comp_rem_next;
            fp_reg       <= fp_next;
            lit_rem_reg  <= lit_rem_next;
            token_reg    <= token_next;
            total_reg    <= total_next;
            failed_reg   <= failed_next;
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

endmodule

FILE: rtl/flz_back.sv
module flz_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  flz_pkg::cmd_t                 q_cmd,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    kind,
    output logic [7:0]                    out_byte,
    output logic [flz_pkg::TOTAL_W-1:0]   total_length,
    output logic                          last
);

    logic [7:0]                     hist_mem [flz_pkg::HISTORY_DEPTH];

    flz_pkg::bk_state_t             state_reg;
    flz_pkg::bk_state_t             state_next;
    logic [flz_pkg::HIST_AW-1:0]    rd_reg;
    logic [flz_pkg::HIST_AW-1:0]    rd_next;
    logic [flz_pkg::HIST_AW-1:0]    wr_reg;
    logic [flz_pkg::HIST_AW-1:0]    wr_next;
    logic [flz_pkg::MLEN_W-1:0]     cnt_reg;
    logic [flz_pkg::MLEN_W-1:0]     cnt_next;
    logic [flz_pkg::TOTAL_W-1:0]    tot_reg;
    logic [flz_pkg::TOTAL_W-1:0]    tot_next;
    logic [7:0]                     rdata_reg;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [1:0]                     kind_reg;
    logic [1:0]                     kind_next;
    logic [7:0]                     byte_reg;
    logic [7:0]                     byte_next;
    logic [flz_pkg::TOTAL_W-1:0]    len_reg;
    logic [flz_pkg::TOTAL_W-1:0]    len_next;
    logic                           last_reg;
    logic                           last_next;

    logic                           load_ok;
    logic                           mem_we;
    logic [flz_pkg::HIST_AW-1:0]    mem_wa;
    logic [7:0]                     mem_wd;
    logic                           mem_re;

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign out_byte     = byte_reg;
    assign total_length = len_reg;
    assign last         = last_reg;

    assign load_ok = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        rd_next        = rd_reg;
        wr_next        = wr_reg;
        cnt_next       = cnt_reg;
        tot_next       = tot_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        len_next       = len_reg;
        last_next      = last_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_wa         = wr_reg;
        mem_wd         = rdata_reg;
        mem_re         = 1'b0;

        unique case (state_reg)
            flz_pkg::BK_IDLE:
            begin
                if (!q_empty && load_ok)
                begin
                    q_pop = 1'b1;
                    unique case (q_cmd.op)
                        flz_pkg::CMD_LIT:
                        begin
                            mem_we         = 1'b1;
                            mem_wa         = q_cmd.wr_addr;
                            mem_wd         = q_cmd.data;
                            out_valid_next = 1'b1;
                            kind_next      = flz_pkg::KIND_BYTE;
                            byte_next      = q_cmd.data;
                            len_next       = q_cmd.total;
                            last_next      = 1'b1;
                        end
                        flz_pkg::CMD_STORED:
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = flz_pkg::KIND_BYTE;
                            byte_next      = q_cmd.data;
                            len_next       = q_cmd.total;
                            last_next      = 1'b1;
                        end
                        flz_pkg::CMD_STATUS:
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = q_cmd.ok ? flz_pkg::KIND_OK : flz_pkg::KIND_FAIL;
                            byte_next      = '0;
                            len_next       = q_cmd.total;
                            last_next      = 1'b1;
                        end
                        flz_pkg::CMD_MATCH:
                        begin
                            rd_next    = q_cmd.rd_addr;
                            wr_next    = q_cmd.wr_addr;
                            cnt_next   = q_cmd.count;
                            tot_next   = q_cmd.total;
                            state_next = flz_pkg::BK_READ;
                        end
                        default:
                        begin
                            state_next = flz_pkg::BK_IDLE;
                        end
                    endcase
                end
            end
            flz_pkg::BK_READ:
            begin
                mem_re     = 1'b1;
                state_next = flz_pkg::BK_COPY;
            end
            flz_pkg::BK_COPY:
            begin
                // The copied byte is written back before the next read, so a
                // match that overlaps its own output sees the fresh bytes.
                if (load_ok)
                begin
                    mem_we         = 1'b1;
                    out_valid_next = 1'b1;
                    kind_next      = flz_pkg::KIND_BYTE;
                    byte_next      = rdata_reg;
                    len_next       = tot_reg;
                    last_next      = (cnt_reg == flz_pkg::MLEN_W'(1));
                    rd_next        = rd_reg + 1'b1;
                    wr_next        = wr_reg + 1'b1;
                    tot_next       = tot_reg + 1'b1;
                    cnt_next       = cnt_reg - 1'b1;
                    state_next     = (cnt_reg == flz_pkg::MLEN_W'(1)) ? flz_pkg::BK_IDLE
                                                                       : flz_pkg::BK_READ;
                end
            end
            default:
            begin
                state_next = flz_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= flz_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg   <= rd_next;
        wr_reg   <= wr_next;
        cnt_reg  <= cnt_next;
        tot_reg  <= tot_next;
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        len_reg  <= len_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rdata_reg <= hist_mem[rd_reg];
        end
    end

endmodule

FILE: rtl/flz_checker.sv
`include "framed_lz_decompressor_unit_macros.svh"

module flz_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [1:0]                    kind,
    input logic [7:0]                    out_byte,
    input logic [flz_pkg::TOTAL_W-1:0]   total_length,
    input logic                          last
);

    logic                           stalled;
    logic                           status_shown;
    logic                           byte_shown;
    logic                           status_fields_ok;
    logic [flz_pkg::TOTAL_W+10:0]   out_word;

    assign stalled          = out_valid && !out_ready;
    assign status_shown     = out_valid && (kind != flz_pkg::KIND_BYTE);
    assign byte_shown       = out_valid && (kind == flz_pkg::KIND_BYTE);
    assign out_word         = {kind, out_byte, total_length, last};
    assign status_fields_ok = last && (out_byte == 8'd0) &&
                              (kind == flz_pkg::KIND_OK || kind == flz_pkg::KIND_FAIL);

    // A stalled result must stay put until the receiver takes it.
    `FLZ_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(out_word), "result changed")

    // A status result is always the only result of its request and has no data.
    `FLZ_ASSERT_HOLDS(a_status_form, status_shown, status_fields_ok, "malformed status result")

    // Every data byte has been counted before it is shown.
    `FLZ_ASSERT_HOLDS(a_byte_counted, byte_shown, total_length != '0, "data byte not counted")

    // The input side must not be blocked by an empty pipeline right after reset.
    `FLZ_ASSERT_HOLDS(a_reset_ready, $rose(rst_n), in_ready || !in_valid, "stuck after reset")

endmodule

bind framed_lz_decompressor_unit flz_checker u_flz_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .out_byte     (out_byte),
    .total_length (total_length),
    .last         (last)
);

FILE: test/tb_framed_lz_decompressor_unit.sv
`timescale 1ns / 100ps

module tb_framed_lz_decompressor_unit;

    localparam logic OP_BYTE     = 1'b0;
    localparam logic OP_END      = 1'b1;
    localparam int   CAP_MAX     = int'(flz_pkg::CAPACITY_RESET);
    localparam int   DRAIN_CYCLES = 64;
    localparam int   STALL_LIMIT  = 4000;

    typedef struct {
        logic       opcode;
        logic [7:0] data;
    } feed_item_t;

    typedef struct {
        logic [1:0]                  kind;
        logic [7:0]                  data;
        logic [flz_pkg::TOTAL_W-1:0] total;
        logic                        last;
    } out_rec_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [flz_pkg::TOTAL_W-1:0] cfg_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic                        opcode = 1'b0;
    logic [7:0]                  in_byte = 8'h00;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [1:0]                  kind;
    logic [7:0]                  out_byte;
    logic [flz_pkg::TOTAL_W-1:0] total_length;
    logic                        last;

    feed_item_t stream_feed[$];
    out_rec_t   expected_out[$];
    logic [7:0] frame_body[$];
    logic [7:0] frame_buf[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int phase_cap = CAP_MAX;
    int fed_cnt = 0;
    int mismatch_cnt = 0;
    int quiet_cycles = 0;

    // Decoder state mirrored for prediction.
    logic [flz_pkg::TOTAL_W-1:0] cap_reg = flz_pkg::CAPACITY_RESET;
    flz_pkg::phase_t             dec_phase;
    logic [1:0]                  hdr_cnt;
    logic [15:0]                 raw_len;
    logic [15:0]                 comp_left;
    logic [8:0]                  made;
    logic [7:0]                  lit_left;
    logic [7:0]                  pend_tok;
    logic [flz_pkg::TOTAL_W-1:0] total_cnt;
    logic                        dec_failed;
    logic [7:0]                  hist [0:flz_pkg::HISTORY_DEPTH-1];

    framed_lz_decompressor_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .out_byte     (out_byte),
        .total_length (total_length),
        .last         (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    task automatic clear_stream_state();
        dec_phase  = flz_pkg::PH_HEADER;
        hdr_cnt    = 2'd0;
        raw_len    = '0;
        comp_left  = '0;
        made       = '0;
        lit_left   = '0;
        pend_tok   = '0;
        total_cnt  = '0;
        dec_failed = 1'b0;
    endtask

    function automatic int unsigned room_bytes();
        return (total_cnt > cap_reg) ? 0 : int'(cap_reg) - int'(total_cnt);
    endfunction

    function automatic void add_result(input logic [1:0] k, input logic [7:0] v);
        out_rec_t rec;
        rec.kind  = k;
        rec.data  = v;
        rec.total = total_cnt;
        rec.last  = 1'b0;
        expected_out.push_back(rec);
    endfunction

    function automatic void store_byte(input logic [7:0] v);
        hist[made % flz_pkg::HISTORY_DEPTH] = v;
        made = made + 9'd1;
        total_cnt = total_cnt + 1'b1;
    endfunction

    // A compressed frame closes once its compressed bytes are used up.
    function automatic void frame_end_check();
        if (comp_left == 16'd0)
        begin
            if (made != raw_len)
                dec_failed = 1'b1;
            dec_phase = flz_pkg::PH_HEADER;
            hdr_cnt = 2'd0;
        end
    endfunction

    task automatic decode_step(input logic op, input logic [7:0] b);
        int unsigned n;
        int unsigned off;
        int          base;
        logic [7:0]  v;
        out_rec_t    rec;
        base = expected_out.size();
        if (op == OP_END)
        begin
            add_result((!dec_failed && dec_phase == flz_pkg::PH_HEADER && hdr_cnt == 2'd0)
                       ? flz_pkg::KIND_OK : flz_pkg::KIND_FAIL, 8'h00);
            clear_stream_state();
        end
        else if (!dec_failed)
        begin
            case (dec_phase)
                flz_pkg::PH_HEADER:
                begin
                    case (hdr_cnt)
                        2'd0: raw_len = {8'h00, b};
                        2'd1: raw_len[15:8] = b;
                        2'd2: comp_left = {8'h00, b};
                        default: comp_left[15:8] = b;
                    endcase
                    hdr_cnt = hdr_cnt + 2'd1;
                    if (hdr_cnt == 2'd0)
                    begin
                        made = '0;
                        if (raw_len == 16'd0 || raw_len > flz_pkg::MAX_FRAME_BYTES
                            || raw_len > room_bytes())
                            dec_failed = 1'b1;
                        else if (comp_left == 16'd0)
                            dec_phase = flz_pkg::PH_STORED;
                        else
                            dec_phase = flz_pkg::PH_TOKEN;
                    end
                end
                flz_pkg::PH_STORED:
                begin
                    made = made + 9'd1;
                    total_cnt = total_cnt + 1'b1;
                    add_result(flz_pkg::KIND_BYTE, b);
                    if (made >= raw_len)
                    begin
                        dec_phase = flz_pkg::PH_HEADER;
                        hdr_cnt = 2'd0;
                    end
                end
                flz_pkg::PH_TOKEN:
                begin
                    comp_left = comp_left - 16'd1;
                    if (!b[7])
                    begin
                        n = b[6:0] + 1;
                        if (n > comp_left || n > room_bytes() || made + n > raw_len)
                            dec_failed = 1'b1;
                        else
                        begin
                            lit_left = n[7:0];
                            dec_phase = flz_pkg::PH_LITERAL;
                        end
                    end
                    else if (comp_left == 16'd0)
                        dec_failed = 1'b1;
                    else
                    begin
                        pend_tok = b;
                        dec_phase = flz_pkg::PH_MATCH;
                    end
                end
                flz_pkg::PH_LITERAL:
                begin
                    comp_left = comp_left - 16'd1;
                    store_byte(b);
                    add_result(flz_pkg::KIND_BYTE, b);
                    lit_left = lit_left - 8'd1;
                    if (lit_left == 8'd0)
                    begin
                        dec_phase = flz_pkg::PH_TOKEN;
                        frame_end_check();
                    end
                end
                default:
                begin
                    n = pend_tok[6:4] + 3;
                    off = {pend_tok[3:0], b};
                    comp_left = comp_left - 16'd1;
                    if (off == 0 || off > made || n > room_bytes() || made + n > raw_len)
                        dec_failed = 1'b1;
                    else
                    begin
                        for (int i = 0; i < n; i++)
                        begin
                            v = hist[(made - off) % flz_pkg::HISTORY_DEPTH];
                            store_byte(v);
                            add_result(flz_pkg::KIND_BYTE, v);
                        end
                        dec_phase = flz_pkg::PH_TOKEN;
                        frame_end_check();
                    end
                end
            endcase
        end
        if (expected_out.size() > base)
        begin
            rec = expected_out.pop_back();
            rec.last = 1'b1;
            expected_out.push_back(rec);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver, monitor, watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic       fire;
        feed_item_t item;
        if (rst_n)
        begin
            fire = in_valid && in_ready;
            if (fire)
                decode_step(opcode, in_byte);
            if (!in_valid || fire)
            begin
                if (stream_feed.size() > 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    item = stream_feed.pop_front();
                    in_valid <= 1'b1;
                    opcode   <= item.opcode;
                    in_byte  <= item.data;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_cnt++;
        end
    endfunction

    always @(posedge clk)
    begin
        out_rec_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_out.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0b",
                             $time, kind, out_byte, total_length, last);
                    mismatch_cnt++;
                end
                else
                begin
                    want = expected_out.pop_front();
                    check_field("kind", want.kind, kind);
                    check_field("out_byte", want.data, out_byte);
                    check_field("total_length", want.total, total_length);
                    check_field("last", want.last, last);
                end
            end
            out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic void push_item(input logic op, input logic [7:0] v);
        feed_item_t item;
        item.opcode = op;
        item.data   = v;
        stream_feed.push_back(item);
        fed_cnt++;
    endfunction

    // Pushes the frame header and body, or only the first cut bytes if cut >= 0.
    function automatic void push_frame(input int raw, input int comp, input int cut);
        frame_buf = {raw[7:0], raw[15:8], comp[7:0], comp[15:8]};
        foreach (frame_body[i])
            frame_buf.push_back(frame_body[i]);
        foreach (frame_buf[i])
            if (cut < 0 || i < cut)
                push_item(OP_BYTE, frame_buf[i]);
    endfunction

    // Up to two ignored bytes, then the end of the stream.
    function automatic void break_off();
        repeat ($urandom_range(2, 0))
            push_item(OP_BYTE, 8'($urandom_range(255, 0)));
        push_item(OP_END, 8'($urandom_range(255, 0)));
    endfunction

    function automatic void add_literal(input int n);
        frame_body.push_back(8'(n - 1));
        repeat (n)
            frame_body.push_back(8'($urandom_range(255, 0)));
    endfunction

    function automatic void add_match(input int n, input int off);
        frame_body.push_back(8'h80 | 8'((n - 3) << 4) | 8'(off >> 8));
        frame_body.push_back(8'(off));
    endfunction

    function automatic void build_compressed(input int raw);
        int done_n;
        int n;
        int match_pct;
        frame_body.delete();
        done_n = 0;
        match_pct = (raw >= 300) ? 85 : 40;
        while (done_n < raw)
        begin
            if (done_n >= 1 && raw - done_n >= 3 && $urandom_range(99, 0) < match_pct)
            begin
                n = $urandom_range((raw - done_n < 10) ? raw - done_n : 10, 3);
                add_match(n, $urandom_range(done_n, 1));
            end
            else
            begin
                n = $urandom_range((raw - done_n < 128) ? raw - done_n : 128, 1);
                add_literal(n);
            end
            done_n += n;
        end
    endfunction

    function automatic int pick_raw(input logic allow_big);
        if (allow_big && $urandom_range(39, 0) == 0)
            return $urandom_range(1, 0) ? flz_pkg::MAX_FRAME_BYTES
                                        : $urandom_range(flz_pkg::MAX_FRAME_BYTES, 400);
        return $urandom_range(24, 1);
    endfunction

    // A frame that violates one bound of the format.
    function automatic void gen_broken();
        int m;
        int n;
        frame_body.delete();
        m = $urandom_range(6, 1);
        case ($urandom_range(8, 0))
            0: push_frame(0, $urandom_range(65535, 0), -1);
            1: push_frame($urandom_range(65535, flz_pkg::MAX_FRAME_BYTES + 1),
                          $urandom_range(65535, 0), -1);
            2:
            begin
                // Literal run longer than the rest of the compressed frame.
                frame_body.push_back(8'(m));
                push_frame(100, m, -1);
            end
            3:
            begin
                // Literal run longer than the rest of the raw length.
                frame_body.push_back(8'(m));
                push_frame(m, 200, -1);
            end
            4:
            begin
                // Match token as the last byte of the frame.
                add_literal(m);
                frame_body.push_back(8'h80 | 8'($urandom_range(127, 0)));
                push_frame(100, frame_body.size(), -1);
            end
            5:
            begin
                n = $urandom_range(10, 3);
                add_literal(m);
                add_match(n, 0);
                push_frame(m + n, frame_body.size(), -1);
            end
            6:
            begin
                add_literal(m);
                add_match(10, $urandom_range(4095, m + 1));
                push_frame(m + 10, frame_body.size(), -1);
            end
            7:
            begin
                n = $urandom_range(10, 3);
                add_literal(m);
                add_match(n, 1);
                push_frame(m + n - 1, frame_body.size(), -1);
            end
            default:
            begin
                // Frame ends short of its raw length.
                add_literal(m);
                push_frame(m + $urandom_range(5, 1), frame_body.size(), -1);
            end
        endcase
    endfunction

    function automatic void gen_stream(input int cap);
        int room_left;
        int raw;
        int comp;
        int pick;
        logic packed_frame;
        room_left = cap;
        repeat ($urandom_range(4, 0))
        begin
            pick = $urandom_range(99, 0);
            if (pick < 12)
            begin
                gen_broken();
                break_off();
                return;
            end
            packed_frame = ($urandom_range(99, 0) < 65);
            raw = pick_raw(packed_frame);
            if (packed_frame)
                build_compressed(raw);
            else
            begin
                frame_body.delete();
                repeat (raw)
                    frame_body.push_back(8'($urandom_range(255, 0)));
            end
            comp = packed_frame ? frame_body.size() : 0;
            if (raw > room_left)
            begin
                push_frame(raw, comp, 4);
                break_off();
                return;
            end
            if (pick >= 90)
            begin
                push_frame(raw, comp, $urandom_range(frame_body.size() + 3, 1));
                push_item(OP_END, 8'($urandom_range(255, 0)));
                return;
            end
            push_frame(raw, comp, -1);
            room_left -= raw;
        end
        push_item(OP_END, 8'($urandom_range(255, 0)));
    endfunction

    task automatic wait_idle();
        while (stream_feed.size() != 0 || in_valid || expected_out.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic start_phase(input int cap, input int snd_pct, input int rcv_pct);
        wait_idle();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= flz_pkg::TOTAL_W'(cap);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cap_reg = flz_pkg::TOTAL_W'(cap);
        @(negedge clk);
        phase_cap = cap;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
    endtask

    task automatic fill_random(input int budget);
        int target;
        target = fed_cnt + budget;
        while (fed_cnt < target)
            gen_stream(phase_cap);
    endtask

    initial
    begin
        clear_stream_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        start_phase(CAP_MAX, 15, 64);
        // Empty stream.
        push_item(OP_END, 8'h00);
        // Stored frame carrying the extreme byte values.
        push_item(OP_BYTE, 8'h02);
        push_item(OP_BYTE, 8'h00);
        push_item(OP_BYTE, 8'h00);
        push_item(OP_BYTE, 8'h00);
        push_item(OP_BYTE, 8'h00);
        push_item(OP_BYTE, 8'hFF);
        // Compressed frame: two literals, then an overlapping match at offset two.
        push_item(OP_BYTE, 8'h05);
        push_item(OP_BYTE, 8'h00);
        push_item(OP_BYTE, 8'h05);
        push_item(OP_BYTE, 8'h00);
        push_item(OP_BYTE, 8'h01);
        push_item(OP_BYTE, 8'h41);
        push_item(OP_BYTE, 8'h42);
        push_item(OP_BYTE, 8'h80);
        push_item(OP_BYTE, 8'h02);
        push_item(OP_END, 8'hFF);
        // Raw length one above the frame limit, a byte that is ignored, then the end.
        push_item(OP_BYTE, 8'hFD);
        push_item(OP_BYTE, 8'h01);
        push_item(OP_BYTE, 8'h00);
        push_item(OP_BYTE, 8'h00);
        push_item(OP_BYTE, 8'hA5);
        push_item(OP_END, 8'h00);
        // Stream cut inside a header.
        push_item(OP_BYTE, 8'h03);
        push_item(OP_END, 8'h00);
        fill_random(60);

        start_phase($urandom_range(300, 30), 15, 64);
        fill_random(60);
        start_phase(0, 64, 15);
        fill_random(20);
        start_phase($urandom_range(1000, 100), 64, 15);
        fill_random(65);
        start_phase(CAP_MAX, 0, 0);
        fill_random(70);
        start_phase($urandom_range(CAP_MAX, 1000), 0, 0);
        fill_random(60);

        wait_idle();
        if (mismatch_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
